### rtl/i2cee_pkg.sv
`default_nettype none
package i2cee_pkg;
  localparam logic [1:0] OP_SDA = 2'd0;
  localparam logic [1:0] OP_SCL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BYTE_IN = 3'd1;
  localparam logic [2:0] PH_ACK_OUT = 3'd2;
  localparam logic [2:0] PH_BYTE_OUT = 3'd3;
  localparam logic [2:0] PH_WAIT_ACK = 3'd4;

  localparam logic [9:0] DEV_WRITE = 10'h1A0;
  localparam logic [9:0] DEV_READ = 10'h1A1;
  localparam logic [9:0] DEV_MASK = 10'h1A1;

  localparam logic CFG_SMALL_MODE = 1'b0;
  localparam logic CFG_BUSY_CYCLES = 1'b1;
  localparam logic [15:0] BUSY_RESET = 16'd5966;

  // Preloaded store pattern: ((a & 255) + 1) * ((a >> 8) + 1) mod 256.
  function automatic logic [7:0] init_byte(input logic [15:0] a);
    logic [15:0] p;
    p = ({8'd0, a[7:0]} + 16'd1) * ({8'd0, a[15:8]} + 16'd1);
    return p[7:0];
  endfunction
endpackage
`default_nettype wire

### rtl/i2cee_store.sv
`default_nettype none
// EEPROM array with a clearing pass after reset that writes the preload pattern.
module i2cee_store #(
  parameter int unsigned MemBytes = 32768
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [$clog2(MemBytes)-1:0] waddr_i,
  input  wire logic [7:0]                  wdata_i,
  input  wire logic [$clog2(MemBytes)-1:0] raddr_i,
  output      logic [7:0]                  rdata_o,
  output      logic                        init_done_o
);
  import i2cee_pkg::*;
  localparam int unsigned AW = $clog2(MemBytes);

  logic [7:0] mem [MemBytes];
  logic [AW:0] init_q, init_d;
  logic [15:0] init_addr;

  assign init_done_o = init_q[AW];
  assign init_d = init_q + 1'b1;
  assign init_addr = 16'(init_q[AW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (!init_q[AW]) begin
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!init_q[AW]) begin
      mem[init_q[AW-1:0]] <= init_byte(init_addr);
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/i2c_eeprom_slave_core.sv
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tdata: opcode[1:0], level[2], now_cycles[34:3]
// m_axis    out        tdata: sda_out[0], bus_phase[3:1]
// cfg       in         index 0 small_mode, index 1 write_busy_cycles
// Each event is accepted, processed and then presented as a result. A clock
// fall that starts a byte out adds the store read states (S_RD, S_RD2). A stop
// that commits a page adds S_COMMIT, which does one store write per cycle for n
// bytes and then a closing step (n is at most PageBytes).
// After reset, a clearing pass preloads the store; no transaction is accepted
// meanwhile. A stalled result holds the block.
module i2c_eeprom_slave_core #(
  parameter int unsigned MemBytes = 32768,
  parameter int unsigned PageBytes = 64,
  parameter int unsigned PacketBytes = 70
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // opcode, level, now_cycles
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // sda_out, bus_phase
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import i2cee_pkg::*;
  localparam int unsigned AW = $clog2(MemBytes);
  localparam int unsigned PW = $clog2(PacketBytes + 1);
  localparam int unsigned GW = $clog2(PageBytes + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD = 3'd2;
  localparam logic [2:0] S_RD2 = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] st_q;
  logic [1:0] op_q;
  logic lvl_q;
  logic [31:0] now_q;
  logic small_q;
  logic [15:0] busy_q;

  logic [7:0] pbuf [PacketBytes];
  logic [7:0] pdata_q;
  logic [7:0] ahi_q, alo_q;
  logic [PW-1:0] prd_idx;
  logic [PW-1:0] pptr_q;
  logic [9:0] bsh_q;
  logic [2:0] ph_q;
  logic [15:0] wa_q;
  logic md_q, mc_q, dd_q;
  logic [31:0] tstart_q;
  logic [GW-1:0] cnt_q;
  logic [PW-1:0] cidx_q;

  logic st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0] st_rdata;
  logic init_done;

  i2cee_store #(.MemBytes(MemBytes)) u_store (
    .clk_i, .rst_ni,
    .we_i(st_we), .waddr_i(st_waddr), .wdata_i(pdata_q),
    .raddr_i(wa_q[AW-1:0]), .rdata_o(st_rdata), .init_done_o(init_done)
  );

  assign st_we = (st_q == S_COMMIT) && (cnt_q != '0);
  assign st_waddr = wa_q[AW-1:0];
  assign s_axis_tready = (st_q == S_IDLE) && init_done;
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata = {4'd0, ph_q, md_q & dd_q};

  // Combinational helpers for a stop that commits and for a byte out.
  logic [PW-1:0] ncount;
  logic [GW-1:0] room;
  logic [GW-1:0] ccount;
  logic [8:0] bnew;
  logic [9:0] shnew;
  always_comb begin
    ncount = pptr_q - PW'(3);
    room = GW'(PageBytes) - GW'(wa_q & 16'(PageBytes - 1));
    ccount = (32'(ncount) > 32'(room)) ? room : GW'(ncount);
    bnew = {st_rdata, 1'b1};
    shnew = {bsh_q[8:0], 1'b0};
  end

  // The buffer read runs one entry ahead so that the registered data meets
  // the store write of the following cycle.
  assign prd_idx = (st_q == S_COMMIT) ? cidx_q + 1'b1 : PW'(3);

  logic [9:0] sh_in;
  logic [9:0] sh_m;
  logic [15:0] wa_ack;
  assign sh_in = {bsh_q[8:0], md_q};
  assign sh_m = (small_q && (sh_in[7:0] & 8'hF0) == 8'hA0) ? (sh_in & DEV_MASK) : sh_in;
  assign wa_ack = (pptr_q == PW'(1)) ? {bsh_q[7:0], alo_q} :
                  (pptr_q == PW'(2)) ? {ahi_q, bsh_q[7:0]} : {ahi_q, alo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_q <= 1'b0;
      busy_q <= BUSY_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SMALL_MODE) small_q <= cfg_wdata_i[0];
      else busy_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_EXEC && op_q == OP_SDA && !lvl_q && md_q && dd_q && mc_q) begin
      pbuf[0] <= 8'd0;
    end else if (st_q == S_EXEC && op_q == OP_SCL && !lvl_q && mc_q) begin
      if (ph_q == PH_BYTE_IN) begin
        if (sh_in[8] && pptr_q == '0) begin
          pbuf[0] <= sh_in[7:0];
          if (small_q && (sh_in[7:0] & 8'hF0) == 8'hA0) ahi_q <= {5'd0, sh_in[3:1]};
        end
      end else if (ph_q == PH_ACK_OUT && bsh_q != '0) begin
        if (pptr_q == '0) pbuf[0] <= bsh_q[7:0];
        else if (32'(pptr_q) < PacketBytes) begin
          pbuf[pptr_q] <= bsh_q[7:0];
          if (pptr_q == PW'(1)) ahi_q <= bsh_q[7:0];
          if (pptr_q == PW'(2)) alo_q <= bsh_q[7:0];
        end
      end
    end
    pdata_q <= pbuf[prd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; op_q <= '0; lvl_q <= 1'b0; now_q <= '0;
      pptr_q <= '0; bsh_q <= '0; ph_q <= PH_IDLE; wa_q <= '0;
      md_q <= 1'b1; mc_q <= 1'b1; dd_q <= 1'b1; tstart_q <= '0;
      cnt_q <= '0; cidx_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          op_q <= s_axis_tdata[1:0]; lvl_q <= s_axis_tdata[2];
          now_q <= s_axis_tdata[34:3]; st_q <= S_EXEC;
        end
        S_EXEC: begin
          st_q <= S_OUT;
          if (op_q == OP_SDA) begin
            if (lvl_q) begin
              if (!md_q && dd_q && mc_q) begin
                ph_q <= PH_IDLE;
                if (ph_q == PH_BYTE_IN && bsh_q == 10'd1 && 32'(pptr_q) > 3) begin
                  tstart_q <= now_q; cnt_q <= ccount; cidx_q <= PW'(3);
                  st_q <= S_COMMIT;
                end
              end
              md_q <= 1'b1;
            end else begin
              if (md_q && dd_q && mc_q) begin
                ph_q <= ((now_q - tstart_q) < {16'd0, busy_q}) ? PH_IDLE : PH_ACK_OUT;
                pptr_q <= '0; bsh_q <= '0;
              end
              md_q <= 1'b0;
            end
          end else if (op_q == OP_SCL) begin
            mc_q <= lvl_q;
            if (!lvl_q && mc_q) begin
              case (ph_q)
                PH_BYTE_IN: begin
                  bsh_q <= sh_in;
                  if (sh_in[8]) begin
                    if (pptr_q == '0) begin
                      bsh_q <= sh_m;
                      if (sh_m == DEV_WRITE) begin ph_q <= PH_ACK_OUT; dd_q <= 1'b0; end
                      else if (sh_m == DEV_READ) begin ph_q <= PH_WAIT_ACK; dd_q <= 1'b0; end
                      else ph_q <= PH_IDLE;
                    end else begin
                      ph_q <= PH_ACK_OUT; dd_q <= 1'b0;
                    end
                  end
                end
                PH_ACK_OUT: begin
                  if (bsh_q != '0) begin
                    if (pptr_q == '0) pptr_q <= small_q ? PW'(2) : PW'(1);
                    else if (32'(pptr_q) < PacketBytes) begin
                      pptr_q <= pptr_q + 1'b1;
                      wa_q <= wa_ack;
                    end
                  end
                  dd_q <= 1'b1; bsh_q <= 10'd1; ph_q <= PH_BYTE_IN;
                end
                PH_WAIT_ACK: begin
                  if (md_q && dd_q) ph_q <= PH_IDLE;
                  else st_q <= S_RD;
                end
                PH_BYTE_OUT: begin
                  dd_q <= bsh_q[8];
                  bsh_q <= shnew;
                  if ((shnew & 10'd510) == '0) begin
                    ph_q <= PH_WAIT_ACK; dd_q <= 1'b1; wa_q <= wa_q + 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_RD: st_q <= S_RD2;
        S_RD2: begin
          ph_q <= PH_BYTE_OUT;
          dd_q <= 1'b1;
          bsh_q <= {bnew[8:0], 1'b0};
          if (({bnew[8:0], 1'b0} & 10'd510) == '0) begin
            ph_q <= PH_WAIT_ACK; wa_q <= wa_q + 1'b1;
          end
          if (!bnew[8]) dd_q <= 1'b0;
          st_q <= S_OUT;
        end
        S_COMMIT: begin
          if (cnt_q == '0) st_q <= S_OUT;
          else begin
            cnt_q <= cnt_q - 1'b1; cidx_q <= cidx_q + 1'b1; wa_q <= wa_q + 1'b1;
          end
        end
        S_OUT: if (m_axis_tready) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
